// ===== rtl/phfe_pkg.sv =====
package phfe_pkg;

    // One header-field record as it leaves the block.
    typedef struct packed {
        logic [4:0]  code;
        logic [47:0] value;
        logic        last;
    } rec_t;

    // At most two field records and the end record come from one frame byte.
    localparam int MAX_REC   = 3;
    localparam int REC_DEPTH = 8;
    localparam int REC_PTR_W = $clog2(REC_DEPTH);
    localparam int REC_CNT_W = $clog2(REC_DEPTH + 1);

    // Records produced by one frame byte, in output order.
    typedef struct packed {
        rec_t [MAX_REC-1:0] recs;
        logic [1:0]         count;
    } rec_group_t;

    // Record codes.
    localparam logic [4:0] CODE_DMAC       = 5'd0;
    localparam logic [4:0] CODE_SMAC       = 5'd1;
    localparam logic [4:0] CODE_ARP_HTYPE  = 5'd2;
    localparam logic [4:0] CODE_ARP_PTYPE  = 5'd3;
    localparam logic [4:0] CODE_ARP_OPER   = 5'd4;
    localparam logic [4:0] CODE_ARP_SHA    = 5'd5;
    localparam logic [4:0] CODE_ARP_SPA    = 5'd6;
    localparam logic [4:0] CODE_ARP_THA    = 5'd7;
    localparam logic [4:0] CODE_ARP_TPA    = 5'd8;
    localparam logic [4:0] CODE_IP_VER     = 5'd9;
    localparam logic [4:0] CODE_IP_TTL     = 5'd10;
    localparam logic [4:0] CODE_IP_PROTO   = 5'd11;
    localparam logic [4:0] CODE_IP_SRC     = 5'd12;
    localparam logic [4:0] CODE_IP_DST     = 5'd13;
    localparam logic [4:0] CODE_ICMP_TYPE  = 5'd14;
    localparam logic [4:0] CODE_TCP_SPORT  = 5'd15;
    localparam logic [4:0] CODE_TCP_DPORT  = 5'd16;
    localparam logic [4:0] CODE_TCP_SEQ    = 5'd17;
    localparam logic [4:0] CODE_TCP_ACK    = 5'd18;
    localparam logic [4:0] CODE_TCP_FLAGS  = 5'd19;
    localparam logic [4:0] CODE_UDP_SPORT  = 5'd20;
    localparam logic [4:0] CODE_UDP_DPORT  = 5'd21;
    localparam logic [4:0] CODE_END        = 5'd22;

    // Protocol constants.
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    // Frame classification, one-hot.
    typedef enum logic [4:0] {
        CLS_UNDECIDED = 5'b00001,
        CLS_ARP_WAIT  = 5'b00010,
        CLS_ARP       = 5'b00100,
        CLS_IPV4      = 5'b01000,
        CLS_NONE      = 5'b10000
    } class_t;

endpackage

// ===== rtl/packet_header_field_extractor_core.sv =====
// Ethernet header field extractor. The frame enters one byte per beat with
// frame_end marking its last byte; header fields leave as tagged records
// (field_code, field_value, record_last) in wire order, and every frame closes
// with an end record whose value is 1 if the frame was dropped for having both
// MAC addresses zero. A byte is accepted whenever frame_ready is high: it is
// decoded in the cycle it is taken, and its records (at most three) go into an
// eight-entry record queue that is drained one record per cycle while rec_ready
// is high. The queue depth sets the throughput limit: frame_ready drops only
// while more than five records wait, which happens only if the record side
// stalls, since most bytes produce no record at all.
module packet_header_field_extractor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        rec_valid,
    input  logic        rec_ready,
    output logic [4:0]  field_code,
    output logic [47:0] field_value,
    output logic        record_last
);
    import phfe_pkg::*;

    logic       beat_fire;
    rec_group_t group;
    rec_t       head;

    assign beat_fire = frame_valid && frame_ready;

    // Byte decode and per-frame state.
    phfe_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_fire  (beat_fire),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .group      (group)
    );

    // Record queue between decode and the output channel.
    phfe_rec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (beat_fire),
        .group      (group),
        .has_room   (frame_ready),
        .head_valid (rec_valid),
        .head_ready (rec_ready),
        .head       (head)
    );

    assign field_code  = head.code;
    assign field_value = head.value;
    assign record_last = head.last;

endmodule

// ===== rtl/phfe_decode.sv =====
module phfe_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat_fire,
    input  logic [7:0]           frame_byte,
    input  logic                 frame_end,
    output phfe_pkg::rec_group_t group
);
    import phfe_pkg::*;

    // Byte offsets at which a field is complete.
    localparam logic [7:0] OFF_DMAC    = 8'd5;
    localparam logic [7:0] OFF_SMAC    = 8'd11;
    localparam logic [7:0] OFF_ETYPE   = 8'd13;
    localparam logic [7:0] OFF_IP_VER  = 8'd14;
    localparam logic [7:0] OFF_ARP_TYP = 8'd17;
    localparam logic [7:0] OFF_ARP_OP  = 8'd21;
    localparam logic [7:0] OFF_ARP_SHA = 8'd27;
    localparam logic [7:0] OFF_ARP_SPA = 8'd31;
    localparam logic [7:0] OFF_ARP_THA = 8'd37;
    localparam logic [7:0] OFF_ARP_TPA = 8'd41;
    localparam logic [7:0] OFF_IP_TTL  = 8'd22;
    localparam logic [7:0] OFF_IP_PROT = 8'd23;
    localparam logic [7:0] OFF_IP_SRC  = 8'd29;
    localparam logic [7:0] OFF_IP_DST  = 8'd33;
    localparam logic [7:0] OFF_MAX     = 8'hFF;

    logic [7:0]  offset_reg, offset_next;
    logic [47:0] gather_reg, gather_next;
    logic [47:0] held_dmac_reg, held_dmac_next;
    class_t      class_reg, class_next;
    logic [7:0]  l4_start_reg, l4_start_next;
    logic [7:0]  proto_reg, proto_next;
    logic        dropped_reg, dropped_next;

    logic [47:0] g;
    logic [7:0]  rel;
    logic [3:0]  ihl;
    logic [1:0]  nf;
    rec_t        f0;
    rec_t        f1;
    rec_t        end_rec;

    // Field decode for the byte on the input.
    always_comb
    begin
        g              = {gather_reg[39:0], frame_byte};
        gather_next    = g;
        held_dmac_next = held_dmac_reg;
        class_next     = class_reg;
        l4_start_next  = l4_start_reg;
        proto_next     = proto_reg;
        dropped_next   = dropped_reg;
        ihl            = frame_byte[3:0];
        rel            = offset_reg - l4_start_reg;
        nf             = 2'd0;
        f0             = '0;
        f1             = '0;

        if (!dropped_reg && offset_reg != OFF_MAX)
        begin
            if (offset_reg == OFF_DMAC)
            begin
                held_dmac_next = g;
            end
            else if (offset_reg == OFF_SMAC)
            begin
                // Both addresses zero drops the frame.
                if (held_dmac_reg == '0 && g == '0)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    nf = 2'd2;
                    f0 = '{code: CODE_DMAC, value: held_dmac_reg, last: 1'b0};
                    f1 = '{code: CODE_SMAC, value: g, last: 1'b0};
                end
            end
            else if (offset_reg == OFF_ETYPE)
            begin
                if (g[15:0] == ETYPE_ARP)
                begin
                    class_next = CLS_ARP_WAIT;
                end
                else if (g[15:0] == ETYPE_IPV4)
                begin
                    class_next = CLS_IPV4;
                end
                else
                begin
                    class_next = CLS_NONE;
                end
            end
            else
            begin
                case (class_reg)
                    CLS_ARP_WAIT:
                    begin
                        if (offset_reg == OFF_ARP_TYP)
                        begin
                            if (g[31:16] == ARP_HTYPE_ETH && g[15:0] == ETYPE_IPV4)
                            begin
                                class_next = CLS_ARP;
                                nf = 2'd2;
                                f0 = '{code: CODE_ARP_HTYPE, value: 48'(g[31:16]),
                                       last: 1'b0};
                                f1 = '{code: CODE_ARP_PTYPE, value: 48'(g[15:0]),
                                       last: 1'b0};
                            end
                            else
                            begin
                                class_next = CLS_NONE;
                            end
                        end
                    end
                    CLS_ARP:
                    begin
                        nf = 2'd1;
                        case (offset_reg)
                            OFF_ARP_OP:  f0 = '{CODE_ARP_OPER, 48'(g[15:0]), 1'b0};
                            OFF_ARP_SHA: f0 = '{CODE_ARP_SHA, g, 1'b0};
                            OFF_ARP_SPA: f0 = '{CODE_ARP_SPA, 48'(g[31:0]), 1'b0};
                            OFF_ARP_THA: f0 = '{CODE_ARP_THA, g, 1'b0};
                            OFF_ARP_TPA: f0 = '{CODE_ARP_TPA, 48'(g[31:0]), 1'b0};
                            default:     nf = 2'd0;
                        endcase
                    end
                    CLS_IPV4:
                    begin
                        nf = 2'd1;
                        if (offset_reg == OFF_IP_VER)
                        begin
                            f0 = '{CODE_IP_VER, 48'(frame_byte[7:4]), 1'b0};
                            // A header length below five words means no layer 4.
                            l4_start_next = (ihl < IHL_MIN) ? 8'd0
                                          : 8'd14 + {2'b00, ihl, 2'b00};
                        end
                        else if (offset_reg == OFF_IP_TTL)
                        begin
                            f0 = '{CODE_IP_TTL, 48'(frame_byte), 1'b0};
                        end
                        else if (offset_reg == OFF_IP_PROT)
                        begin
                            proto_next = frame_byte;
                            f0 = '{CODE_IP_PROTO, 48'(frame_byte), 1'b0};
                        end
                        else if (offset_reg == OFF_IP_SRC)
                        begin
                            f0 = '{CODE_IP_SRC, 48'(g[31:0]), 1'b0};
                        end
                        else if (offset_reg == OFF_IP_DST)
                        begin
                            f0 = '{CODE_IP_DST, 48'(g[31:0]), 1'b0};
                        end
                        else if (l4_start_reg != 8'd0 && offset_reg >= l4_start_reg)
                        begin
                            // Layer 4 fields by offset into that header.
                            nf = 2'd0;
                            if (proto_reg == PROTO_ICMP)
                            begin
                                if (rel == 8'd0)
                                begin
                                    nf = 2'd1;
                                    f0 = '{CODE_ICMP_TYPE, 48'(frame_byte), 1'b0};
                                end
                            end
                            else if (proto_reg == PROTO_TCP)
                            begin
                                nf = 2'd1;
                                case (rel)
                                    8'd1:    f0 = '{CODE_TCP_SPORT, 48'(g[15:0]), 1'b0};
                                    8'd3:    f0 = '{CODE_TCP_DPORT, 48'(g[15:0]), 1'b0};
                                    8'd7:    f0 = '{CODE_TCP_SEQ, 48'(g[31:0]), 1'b0};
                                    8'd11:   f0 = '{CODE_TCP_ACK, 48'(g[31:0]), 1'b0};
                                    8'd13:   f0 = '{CODE_TCP_FLAGS, 48'(frame_byte[5:0]),
                                                    1'b0};
                                    default: nf = 2'd0;
                                endcase
                            end
                            else if (proto_reg == PROTO_UDP)
                            begin
                                nf = 2'd1;
                                case (rel)
                                    8'd1:    f0 = '{CODE_UDP_SPORT, 48'(g[15:0]), 1'b0};
                                    8'd3:    f0 = '{CODE_UDP_DPORT, 48'(g[15:0]), 1'b0};
                                    default: nf = 2'd0;
                                endcase
                            end
                        end
                        else
                        begin
                            nf = 2'd0;
                        end
                    end
                    default:
                    begin
                        nf = 2'd0;
                    end
                endcase
            end
        end

        // The end record reports the drop decision including this byte's.
        end_rec = '{code: CODE_END, value: 48'(dropped_next), last: 1'b1};

        group.recs[0] = (nf != 2'd0) ? f0 : end_rec;
        group.recs[1] = (nf == 2'd2) ? f1 : end_rec;
        group.recs[2] = end_rec;
        group.count   = nf + {1'b0, frame_end};

        // Per-frame state clears after the last byte.
        if (frame_end)
        begin
            offset_next    = 8'd0;
            gather_next    = '0;
            held_dmac_next = '0;
            class_next     = CLS_UNDECIDED;
            l4_start_next  = 8'd0;
            proto_next     = 8'd0;
            dropped_next   = 1'b0;
        end
        else if (offset_reg != OFF_MAX)
        begin
            offset_next = offset_reg + 8'd1;
        end
        else
        begin
            offset_next = offset_reg;
        end
    end

    // Frame state advances on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= 8'd0;
            gather_reg    <= '0;
            held_dmac_reg <= '0;
            class_reg     <= CLS_UNDECIDED;
            l4_start_reg  <= 8'd0;
            proto_reg     <= 8'd0;
            dropped_reg   <= 1'b0;
        end
        else if (beat_fire)
        begin
            offset_reg    <= offset_next;
            gather_reg    <= gather_next;
            held_dmac_reg <= held_dmac_next;
            class_reg     <= class_next;
            l4_start_reg  <= l4_start_next;
            proto_reg     <= proto_next;
            dropped_reg   <= dropped_next;
        end
    end

    // A closing beat restarts the frame at offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        beat_fire && frame_end |=> offset_reg == 8'd0 && !dropped_reg)
        else $error("frame state not cleared after last beat");

    // Three records only happen when the end record follows two fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        group.count == 2'd3 |-> group.recs[2].last && !group.recs[1].last)
        else $error("record group out of order");

    // A dropped frame yields nothing but its end record.
    assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> group.count == {1'b0, frame_end})
        else $error("field record from a dropped frame");

endmodule

// ===== rtl/phfe_rec_queue.sv =====
module phfe_rec_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  phfe_pkg::rec_group_t group,
    output logic                 has_room,
    output logic                 head_valid,
    input  logic                 head_ready,
    output phfe_pkg::rec_t       head
);
    import phfe_pkg::*;

    rec_t                 mem_reg [REC_DEPTH];
    logic [REC_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [REC_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [REC_CNT_W-1:0] count_reg, count_next;
    logic [REC_CNT_W-1:0] push_cnt;
    logic                 pop;

    // Occupancy and pointer update.
    always_comb
    begin
        pop         = head_valid && head_ready;
        push_cnt    = push ? REC_CNT_W'(group.count) : '0;
        wr_ptr_next = wr_ptr_reg + REC_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + REC_PTR_W'(pop);
        count_next  = count_reg + push_cnt - REC_CNT_W'(pop);
    end

    assign has_room   = count_reg <= REC_CNT_W'(REC_DEPTH - MAX_REC);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the beat's records in consecutive slots.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_REC; k++)
        begin
            if (push && k < int'(group.count))
            begin
                mem_reg[wr_ptr_reg + REC_PTR_W'(k)] <= group.recs[k];
            end
        end
    end

    // Occupancy never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= REC_CNT_W'(REC_DEPTH))
        else $error("record queue overflow");

    // A push only lands when a full group fits.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg + REC_CNT_W'(MAX_REC) <= REC_CNT_W'(REC_DEPTH))
        else $error("push without room");

    // Occupancy and pointer distance agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != REC_CNT_W'(REC_DEPTH)
            |-> REC_PTR_W'(wr_ptr_reg - rd_ptr_reg) == REC_PTR_W'(count_reg))
        else $error("queue pointers inconsistent");

endmodule
